FILE: rtl/core/ilfp_pkg.sv
// ---------------------------------------------------------------------------
// ilfp_pkg
// shared types and constants of the irc line field parser
// ---------------------------------------------------------------------------
package ilfp_pkg;

  // parser phase within one message
  typedef enum logic [3:0] {
    PH_START    = 4'd0,
    PH_SRC      = 4'd1,
    PH_SRC_SP   = 4'd2,
    PH_CMD      = 4'd3,
    PH_CMD_SP   = 4'd4,
    PH_NUM_SKIP = 4'd5,
    PH_DEST     = 4'd6,
    PH_DEST_SP  = 4'd7,
    PH_FIND     = 4'd8,
    PH_PARAMS   = 4'd9,
    PH_PING_SP  = 4'd10,
    PH_PING_PAR = 4'd11
  } phase_t;

  // field kinds on the result side
  localparam logic [2:0] KIND_SRC  = 3'd0;
  localparam logic [2:0] KIND_CMD  = 3'd1;
  localparam logic [2:0] KIND_DEST = 3'd2;
  localparam logic [2:0] KIND_PAR  = 3'd3;
  localparam logic [2:0] KIND_END  = 3'd4;

  // character codes
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_COLON = 8'h3a;

  typedef struct packed {
    phase_t     phase;
    logic       cr_held;
    logic [2:0] cmd_len;
    logic       ping_match;
    logic       num_match;
    logic       token_cut;
    logic       skip_spaces;
  } state_t;

  localparam state_t ST_RESET = '{
    phase:       PH_START,
    cr_held:     1'b0,
    cmd_len:     3'd0,
    ping_match:  1'b1,
    num_match:   1'b1,
    token_cut:   1'b0,
    skip_spaces: 1'b0
  };

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] chr;
    logic       ping;
    logic       last;
  } res_t;

  // results caused by one byte, compacted to the front
  typedef struct packed {
    logic [1:0] count;
    res_t       first;
    res_t       second;
  } res_pair_t;

endpackage

FILE: rtl/core/ilfp_step.sv
// ---------------------------------------------------------------------------
// ilfp_step
// next parser state and up to two tagged results for one received byte
// ---------------------------------------------------------------------------
module ilfp_step
  import ilfp_pkg::*;
(
  input  state_t     st,
  input  logic [7:0] rx_byte,
  output state_t     st_next,
  output res_pair_t  res
);

  typedef struct packed {
    state_t     st;
    logic       emit;
    logic [2:0] kind;
    logic [7:0] chr;
  } hres_t;

  function automatic logic [7:0] ping_char(input logic [1:0] idx);
    logic [7:0] c;
    unique case (idx)
      2'd0:    c = 8'h50;
      2'd1:    c = 8'h49;
      2'd2:    c = 8'h4e;
      default: c = 8'h47;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] list_char(input logic [1:0] idx);
    logic [7:0] c;
    unique case (idx)
      2'd1:    c = 8'h35;
      default: c = 8'h33;
    endcase
    return c;
  endfunction

  // one ordinary byte through the field tagger
  function automatic hres_t handle(input state_t s, input logic [7:0] b);
    hres_t r;
    logic  done;
    r.st   = s;
    r.emit = 1'b0;
    r.kind = KIND_PAR;
    r.chr  = b;
    done   = 1'b0;
    if (r.st.phase == PH_START) begin
      if (b == CH_COLON) begin
        r.st.phase     = PH_SRC;
        r.st.token_cut = 1'b0;
        done           = 1'b1;
      end else begin
        r.st.phase = PH_CMD;
      end
    end
    if (!done && r.st.phase == PH_SRC_SP) begin
      if (b == CH_SPACE) done = 1'b1;
      else               r.st.phase = PH_CMD;
    end
    if (!done && r.st.phase == PH_CMD_SP) begin
      if (b == CH_SPACE) begin
        done = 1'b1;
      end else begin
        r.st.token_cut = 1'b0;
        r.st.phase = (r.st.num_match && r.st.cmd_len == 3'd3) ? PH_NUM_SKIP : PH_DEST;
      end
    end
    if (!done && r.st.phase == PH_NUM_SKIP) begin
      if (b != CH_HASH && b != CH_AMP) done = 1'b1;
      else                             r.st.phase = PH_DEST;
    end
    if (!done) begin
      unique case (r.st.phase)
        PH_SRC: begin
          if (b == CH_SPACE) begin
            r.st.phase = PH_SRC_SP;
          end else begin
            if (b == CH_BANG) r.st.token_cut = 1'b1;
            if (!r.st.token_cut) begin
              r.emit = 1'b1;
              r.kind = KIND_SRC;
            end
          end
        end
        PH_CMD: begin
          if (b == CH_SPACE) begin
            r.st.phase = (r.st.ping_match && r.st.cmd_len == 3'd4) ? PH_PING_SP : PH_CMD_SP;
          end else begin
            if (r.st.cmd_len >= 3'd4 || b != ping_char(r.st.cmd_len[1:0]))
              r.st.ping_match = 1'b0;
            if (r.st.cmd_len >= 3'd3 || b != list_char(r.st.cmd_len[1:0]))
              r.st.num_match = 1'b0;
            if (r.st.cmd_len != 3'd7) r.st.cmd_len = r.st.cmd_len + 3'd1;
            r.emit = 1'b1;
            r.kind = KIND_CMD;
          end
        end
        PH_DEST: begin
          if (b == CH_COLON) begin
            r.st.phase = PH_PARAMS;
          end else if (b == CH_SPACE) begin
            r.st.phase = PH_DEST_SP;
          end else begin
            if (b == CH_BANG) r.st.token_cut = 1'b1;
            if (!r.st.token_cut) begin
              r.emit = 1'b1;
              r.kind = KIND_DEST;
            end
          end
        end
        PH_DEST_SP, PH_FIND: begin
          if (b == CH_COLON)      r.st.phase = PH_PARAMS;
          else if (b != CH_SPACE) r.st.phase = PH_FIND;
        end
        PH_PING_SP: begin
          if (b != CH_SPACE) begin
            r.st.phase = PH_PING_PAR;
            r.emit     = 1'b1;
            r.kind     = KIND_PAR;
          end
        end
        default: begin
          r.emit = 1'b1;
          r.kind = KIND_PAR;
        end
      endcase
    end
    return r;
  endfunction

  state_t s;
  hres_t  h_cr;
  hres_t  h_b;
  logic   go;
  logic   r0_valid;
  logic   r1_valid;
  res_t   r0;
  res_t   r1;

  always_comb begin
    s        = st;
    go       = 1'b0;
    r0_valid = 1'b0;
    r1_valid = 1'b0;
    r0       = '0;
    r1       = '0;
    h_cr     = '0;
    h_b      = '0;
    if (rx_byte != CH_NUL) begin
      go = 1'b1;
      if (s.cr_held) begin
        s.cr_held = 1'b0;
        if (rx_byte == CH_LF) begin
          // end of message
          r0_valid      = 1'b1;
          r0.kind       = KIND_END;
          r0.chr        = CH_NUL;
          r0.ping       = (s.phase == PH_PING_SP) || (s.phase == PH_PING_PAR);
          s.phase       = PH_START;
          s.cmd_len     = 3'd0;
          s.ping_match  = 1'b1;
          s.num_match   = 1'b1;
          s.token_cut   = 1'b0;
          s.skip_spaces = 1'b1;
          go            = 1'b0;
        end else begin
          // lone cr is an ordinary byte
          s.skip_spaces = 1'b0;
          h_cr          = handle(s, CH_CR);
          s             = h_cr.st;
          r0_valid      = h_cr.emit;
          r0.kind       = h_cr.kind;
          r0.chr        = h_cr.chr;
        end
      end
      if (go && s.skip_spaces) begin
        if (rx_byte == CH_SPACE) go = 1'b0;
        else                     s.skip_spaces = 1'b0;
      end
      if (go) begin
        if (rx_byte == CH_CR) begin
          s.cr_held = 1'b1;
        end else begin
          h_b      = handle(s, rx_byte);
          s        = h_b.st;
          r1_valid = h_b.emit;
          r1.kind  = h_b.kind;
          r1.chr   = h_b.chr;
        end
      end
    end
    st_next = s;

    res = '0;
    if (r0_valid && r1_valid) begin
      res.count       = 2'd2;
      res.first       = r0;
      res.second      = r1;
      res.second.last = 1'b1;
    end else if (r0_valid) begin
      res.count      = 2'd1;
      res.first      = r0;
      res.first.last = 1'b1;
    end else if (r1_valid) begin
      res.count      = 2'd1;
      res.first      = r1;
      res.first.last = 1'b1;
    end
  end

endmodule

FILE: rtl/core/irc_line_field_parser_top.sv
// ---------------------------------------------------------------------------
// irc_line_field_parser_top
// streaming irc line splitter that tags every kept byte with its field
// ---------------------------------------------------------------------------
// channel  | direction | tdata            | tuser                 | tlast
// s_axis   | in        | [7:0] rx_byte    | -                     | -
// m_axis   | out       | [7:0] char_value | [2:0] field_kind,     | run_last
//          |           |                  | [3] ping_seen         |
//
// one byte is taken per clock while s_axis_tready is high; the parser state and the result queue update
// in the cycle of acceptance, results appear on m_axis the next cycle
// a byte that gives two results (a lone cr and the byte after it) holds off
// s_axis while the first word drains from the queue
// rst is synchronous, active high; it returns the parser to the start of a
// message and empties the queue
// a stall on m_axis holds the queue head; s_axis is ready again as soon as
// the queue is empty after this cycle's pop
// ---------------------------------------------------------------------------
module irc_line_field_parser_top
  import ilfp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] rx_byte
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] char_value
  output logic [3:0] m_axis_tuser,   // [2:0] field_kind, [3] ping_seen
  output logic       m_axis_tlast    // run_last
);

  // parser state
  state_t     st;
  state_t     st_next;
  res_pair_t  res;

  // two-word result queue, head in q0
  res_t       q0;
  res_t       q1;
  logic [1:0] cnt;

  logic       in_take;
  logic       out_pop;

  ilfp_step u_step (
    .st      (st),
    .rx_byte (s_axis_tdata),
    .st_next (st_next),
    .res     (res)
  );

  assign out_pop       = m_axis_tvalid && m_axis_tready;
  // new byte only when the queue is empty after this cycle's pop
  assign s_axis_tready = (cnt == 2'd0) || (cnt == 2'd1 && m_axis_tready);
  assign in_take       = s_axis_tvalid && s_axis_tready;

  // parser state register
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= ST_RESET;
    end else if (in_take) begin
      st <= st_next;
    end
  end

  // queue occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else if (in_take) begin
      cnt <= res.count;
    end else if (out_pop) begin
      cnt <= cnt - 2'd1;
    end
  end

  // queue payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_take) begin
      q0 <= res.first;
      q1 <= res.second;
    end else if (out_pop) begin
      q0 <= q1;
    end
  end

  assign m_axis_tvalid = (cnt != 2'd0);
  assign m_axis_tdata  = q0.chr;
  assign m_axis_tuser  = {q0.ping, q0.kind};
  assign m_axis_tlast  = q0.last;

endmodule

FILE: rtl/core/ilfp_checker.sv
// ---------------------------------------------------------------------------
// ilfp_checker
// port-level checks on the irc line field parser
// ---------------------------------------------------------------------------
module ilfp_checker
  import ilfp_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic [3:0] m_axis_tuser,
  input logic       m_axis_tlast
);

  // stalled word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
      $stable(m_axis_tlast))
    else $error("stalled output word changed");

  // end marker carries no byte and closes its run
  a_end: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[2:0] == KIND_END |->
      m_axis_tdata == CH_NUL && m_axis_tlast)
    else $error("bad end marker");

  // ping flag only on end marker
  a_ping: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[2:0] != KIND_END |-> !m_axis_tuser[3])
    else $error("ping flag outside end marker");

  // reset empties the output
  a_rst: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("output valid after reset");

endmodule

bind irc_line_field_parser_top ilfp_checker u_ilfp_checker (.*);
